@@ sv/rhc_pkg.sv @@
// Shared types and helpers for the RGB to HSV converter.
// Used by the front stage, the divider cells, the top level and the checker.
package rhc_pkg;

  // Control that travels with each item down the pipeline
  typedef struct packed {
    logic valid;  // stage holds an item
    logic grey;   // all components equal: hue undefined, saturation zero
  } rhc_ctl_t;

  // Round a bit count up to whole bytes
  function automatic int bytes_up(input int bits);
    return ((bits + 7) >> 3) << 3;
  endfunction

endpackage

@@ sv/rhc_front.sv @@
// Front stage of the RGB to HSV converter: max, min, hue sector numerator,
// hue divisor and saturation dividend, registered. Depends on rhc_pkg.
module rhc_front import rhc_pkg::*; #(
  parameter int COMPONENT_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [COMPONENT_BITS-1:0]   red,
  input  logic [COMPONENT_BITS-1:0]   green,
  input  logic [COMPONENT_BITS-1:0]   blue,
  output rhc_ctl_t                    ctl_o,
  output logic [COMPONENT_BITS+2:0]   hrem_o,
  output logic [COMPONENT_BITS+2:0]   hdiv_o,
  output logic [COMPONENT_BITS-1:0]   srem_o,
  output logic [COMPONENT_BITS-1:0]   slow_o,
  output logic [COMPONENT_BITS-1:0]   top_o
);

  localparam int CB = COMPONENT_BITS;

  logic [CB-1:0]          top, bot, delta;
  logic signed [CB+3:0]   rx, gx, bx, dx, d6, num;
  logic [2*CB-1:0]        sat_num;

  logic                   valid_r;
  logic                   grey_r;
  logic [CB+2:0]          hrem_r, hdiv_r;
  logic [CB-1:0]          srem_r, slow_r, top_r;

  // Find largest and smallest component
  always_comb begin
    top = (red > green) ? red : green;
    if (blue > top) begin
      top = blue;
    end
    bot = (red < green) ? red : green;
    if (blue < bot) begin
      bot = blue;
    end
    delta = top - bot;
  end

  // Hue numerator: sector offset plus difference, wrapped by one turn
  always_comb begin
    rx  = $signed({4'b0000, red});
    gx  = $signed({4'b0000, green});
    bx  = $signed({4'b0000, blue});
    dx  = $signed({4'b0000, delta});
    d6  = (dx <<< 2) + (dx <<< 1);
    priority if (red == top) begin
      num = gx - bx;
    end else if (green == top) begin
      num = (dx <<< 1) + bx - rx;
    end else begin
      num = (dx <<< 2) + rx - gx;
    end
    if (num[CB+3]) begin
      num = num + d6;
    end
  end

  // Saturation dividend FULL*delta, formed as delta*2^CB - delta
  assign sat_num = {delta, {CB{1'b0}}} - {{CB{1'b0}}, delta};

  // Hold control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (en) begin
      grey_r <= (delta == '0);
      hrem_r <= num[CB+2:0];
      hdiv_r <= d6[CB+2:0];
      srem_r <= sat_num[2*CB-1:CB];
      slow_r <= sat_num[CB-1:0];
      top_r  <= top;
    end
  end

  assign ctl_o.valid = valid_r;
  assign ctl_o.grey  = grey_r;
  assign hrem_o      = hrem_r;
  assign hdiv_o      = hdiv_r;
  assign srem_o      = srem_r;
  assign slow_o      = slow_r;
  assign top_o       = top_r;

endmodule

@@ sv/rhc_div_cell.sv @@
// One divider chain cell: one restoring step of the hue division and one
// of saturation, each if IDX < its width; registered. Depends on rhc_pkg.
module rhc_div_cell import rhc_pkg::*; #(
  parameter int COMPONENT_BITS = 8,
  parameter int HUE_BITS       = 16,
  parameter int IDX            = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  rhc_ctl_t                    ctl_i,
  input  logic [COMPONENT_BITS+2:0]   hrem_i,
  input  logic [COMPONENT_BITS+2:0]   hdiv_i,
  input  logic [HUE_BITS-1:0]         hq_i,
  input  logic [COMPONENT_BITS-1:0]   srem_i,
  input  logic [COMPONENT_BITS-1:0]   slow_i,
  input  logic [COMPONENT_BITS-1:0]   top_i,
  input  logic [COMPONENT_BITS-1:0]   sq_i,
  output rhc_ctl_t                    ctl_o,
  output logic [COMPONENT_BITS+2:0]   hrem_o,
  output logic [COMPONENT_BITS+2:0]   hdiv_o,
  output logic [HUE_BITS-1:0]         hq_o,
  output logic [COMPONENT_BITS-1:0]   srem_o,
  output logic [COMPONENT_BITS-1:0]   slow_o,
  output logic [COMPONENT_BITS-1:0]   top_o,
  output logic [COMPONENT_BITS-1:0]   sq_o
);

  localparam int CB     = COMPONENT_BITS;
  localparam int HB     = HUE_BITS;
  localparam bit HUE_ON = (IDX < HB);
  localparam bit SAT_ON = (IDX < CB);

  logic [CB+3:0]  ht, hsub;
  logic           hge;
  logic [CB:0]    st, ssub;
  logic           sge;

  logic           valid_r, grey_r;
  logic [CB+2:0]  hrem_r, hrem_nxt, hdiv_r;
  logic [HB-1:0]  hq_r, hq_nxt;
  logic [CB-1:0]  srem_r, srem_nxt, slow_r, slow_nxt, top_r, sq_r, sq_nxt;

  // Hue step: shift in a zero, subtract the divisor where it fits
  always_comb begin
    ht   = {hrem_i, 1'b0};
    hsub = ht - {1'b0, hdiv_i};
    hge  = (ht >= {1'b0, hdiv_i});
    if (HUE_ON) begin
      hrem_nxt = hge ? hsub[CB+2:0] : ht[CB+2:0];
      hq_nxt   = {hq_i[HB-2:0], hge};
    end else begin
      hrem_nxt = hrem_i;
      hq_nxt   = hq_i;
    end
  end

  // Saturation step: shift in the next dividend bit, subtract where it fits
  always_comb begin
    st   = {srem_i, slow_i[CB-1]};
    ssub = st - {1'b0, top_i};
    sge  = (st >= {1'b0, top_i});
    if (SAT_ON) begin
      srem_nxt = sge ? ssub[CB-1:0] : st[CB-1:0];
      slow_nxt = {slow_i[CB-2:0], 1'b0};
      sq_nxt   = {sq_i[CB-2:0], sge};
    end else begin
      srem_nxt = srem_i;
      slow_nxt = slow_i;
      sq_nxt   = sq_i;
    end
  end

  // Advance control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctl_i.valid;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      grey_r <= ctl_i.grey;
      hrem_r <= hrem_nxt;
      hdiv_r <= hdiv_i;
      hq_r   <= hq_nxt;
      srem_r <= srem_nxt;
      slow_r <= slow_nxt;
      top_r  <= top_i;
      sq_r   <= sq_nxt;
    end
  end

  assign ctl_o.valid = valid_r;
  assign ctl_o.grey  = grey_r;
  assign hrem_o      = hrem_r;
  assign hdiv_o      = hdiv_r;
  assign hq_o        = hq_r;
  assign srem_o      = srem_r;
  assign slow_o      = slow_r;
  assign top_o       = top_r;
  assign sq_o        = sq_r;

endmodule

@@ sv/rgb_to_hsv_converter_unit.sv @@
// Top level of the RGB to HSV converter: front stage, chain of divider cells
// and a skid output register. Depends on rhc_pkg, rhc_front, rhc_div_cell.
//
// Usage:
//   Input channel in_*: one pixel per item, red, green and blue packed in
//   in_tdata. Output channel out_*: hue, saturation and brightness in
//   out_tdata, the hue-defined flag in out_tuser.
//   From acceptance to out_tvalid an item passes one front stage, one
//   divider cell per quotient bit of the longer division and one output
//   register. Throughput is one pixel per clock while the chain is not
//   held; each cell computes one quotient bit of hue while hue bits remain
//   and one of saturation while saturation bits remain.
//   When the receiver stalls, the item behind the output register moves
//   into a skid register; only then in_tready drops and the whole chain
//   holds. in_tready is a register output and does not depend on
//   out_tready in the same cycle.
//   Synchronous reset empties the chain and both output registers; the
//   block takes items from the first cycle after reset.
module rgb_to_hsv_converter_unit import rhc_pkg::*; #(
  parameter int COMPONENT_BITS = 8,
  parameter int HUE_BITS       = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // red, green, blue (from the lowest bit up)
  input  logic [bytes_up(3*COMPONENT_BITS)-1:0]        in_tdata,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // hue, saturation, brightness (from the lowest bit up)
  output logic [bytes_up(HUE_BITS+2*COMPONENT_BITS)-1:0] out_tdata,
  // hue_valid
  output logic [0:0]                                   out_tuser
);

  localparam int CB    = COMPONENT_BITS;
  localparam int HB    = HUE_BITS;
  localparam int NSTEP = (HB > CB) ? HB : CB;

  logic           en;
  rhc_ctl_t       ctl_w  [NSTEP+1];
  logic [CB+2:0]  hrem_w [NSTEP+1];
  logic [CB+2:0]  hdiv_w [NSTEP+1];
  logic [HB-1:0]  hq_w   [NSTEP+1];
  logic [CB-1:0]  srem_w [NSTEP+1];
  logic [CB-1:0]  slow_w [NSTEP+1];
  logic [CB-1:0]  top_w  [NSTEP+1];
  logic [CB-1:0]  sq_w   [NSTEP+1];

  logic           take_last, out_free;
  logic [HB-1:0]  last_hue;
  logic [CB-1:0]  last_sat;

  logic           out_valid_r, skid_valid_r;
  logic [HB-1:0]  out_hue_r, skid_hue_r;
  logic           out_hv_r, skid_hv_r;
  logic [CB-1:0]  out_sat_r, skid_sat_r, out_bri_r, skid_bri_r;

  // Chain advances while the skid register is free
  assign en        = !skid_valid_r;
  assign in_tready = en;

  rhc_front #(.COMPONENT_BITS(CB)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .red      (in_tdata[0 +: CB]),
    .green    (in_tdata[CB +: CB]),
    .blue     (in_tdata[2*CB +: CB]),
    .ctl_o    (ctl_w[0]),
    .hrem_o   (hrem_w[0]),
    .hdiv_o   (hdiv_w[0]),
    .srem_o   (srem_w[0]),
    .slow_o   (slow_w[0]),
    .top_o    (top_w[0])
  );

  assign hq_w[0] = '0;
  assign sq_w[0] = '0;

  // One cell per quotient bit
  for (genvar k = 0; k < NSTEP; k++) begin : g_cell
    rhc_div_cell #(
      .COMPONENT_BITS (CB),
      .HUE_BITS       (HB),
      .IDX            (k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (ctl_w[k]),
      .hrem_i (hrem_w[k]),
      .hdiv_i (hdiv_w[k]),
      .hq_i   (hq_w[k]),
      .srem_i (srem_w[k]),
      .slow_i (slow_w[k]),
      .top_i  (top_w[k]),
      .sq_i   (sq_w[k]),
      .ctl_o  (ctl_w[k+1]),
      .hrem_o (hrem_w[k+1]),
      .hdiv_o (hdiv_w[k+1]),
      .hq_o   (hq_w[k+1]),
      .srem_o (srem_w[k+1]),
      .slow_o (slow_w[k+1]),
      .top_o  (top_w[k+1]),
      .sq_o   (sq_w[k+1])
    );
  end

  // Drop quotients of a grey pixel: both read zero
  assign last_hue  = ctl_w[NSTEP].grey ? '0 : hq_w[NSTEP];
  assign last_sat  = ctl_w[NSTEP].grey ? '0 : sq_w[NSTEP];
  assign take_last = en && ctl_w[NSTEP].valid;
  assign out_free  = out_tready || !out_valid_r;

  // Output and skid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= take_last;
      end
    end else if (take_last) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_hue_r <= skid_hue_r;
        out_hv_r  <= skid_hv_r;
        out_sat_r <= skid_sat_r;
        out_bri_r <= skid_bri_r;
      end else begin
        out_hue_r <= last_hue;
        out_hv_r  <= !ctl_w[NSTEP].grey;
        out_sat_r <= last_sat;
        out_bri_r <= top_w[NSTEP];
      end
    end else if (take_last) begin
      skid_hue_r <= last_hue;
      skid_hv_r  <= !ctl_w[NSTEP].grey;
      skid_sat_r <= last_sat;
      skid_bri_r <= top_w[NSTEP];
    end
  end

  // Pack the result item
  always_comb begin
    out_tdata              = '0;
    out_tdata[0 +: HB]     = out_hue_r;
    out_tdata[HB +: CB]    = out_sat_r;
    out_tdata[HB+CB +: CB] = out_bri_r;
  end

  assign out_tuser  = out_hv_r;
  assign out_tvalid = out_valid_r;

endmodule

@@ sv/rhc_checker.sv @@
// Port-level checker for the RGB to HSV converter, bound to the top level.
// Depends on rhc_pkg and rgb_to_hsv_converter_unit.
module rhc_checker import rhc_pkg::*; #(
  parameter int COMPONENT_BITS = 8,
  parameter int HUE_BITS       = 16
) (
  input logic                                           clk,
  input logic                                           rst_n,
  input logic                                           out_tvalid,
  input logic                                           out_tready,
  input logic [bytes_up(HUE_BITS+2*COMPONENT_BITS)-1:0] out_tdata,
  input logic [0:0]                                     out_tuser
);

  localparam int CB = COMPONENT_BITS;
  localparam int HB = HUE_BITS;

  // Stalled item stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item withdrawn while stalled");

  // Stalled item keeps its data
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // Grey pixel: hue and saturation read zero
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      out_tdata[0 +: HB] == '0 && out_tdata[HB +: CB] == '0)
    else $error("grey pixel with nonzero hue or saturation");

  // Defined hue implies a colored, non-black pixel
  a_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[HB +: CB] != '0 && out_tdata[HB+CB +: CB] != '0)
    else $error("defined hue with zero saturation or brightness");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result item offered right after reset");

endmodule

bind rgb_to_hsv_converter_unit rhc_checker #(
  .COMPONENT_BITS (COMPONENT_BITS),
  .HUE_BITS       (HUE_BITS)
) u_rhc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
